[sv/xed_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the entity decoder.
package xed_pkg;

  localparam int ENTITY_WINDOW = 11;
  localparam int CNT_W = $clog2(ENTITY_WINDOW + 1);
  localparam int IDX_W = $clog2(ENTITY_WINDOW);
  localparam int CP_W = 21;
  localparam int CP_SUM_W = CP_W + 4;
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SAT = 21'h110000;

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FLUSH_AMP,
    ST_FLUSH_HELD,
    ST_PARSE,
    ST_NUM_CHK,
    ST_UTF,
    ST_RAW_AMP,
    ST_RAW_HELD,
    ST_RAW_SEMI
  } state_t;

  typedef enum logic [2:0] {
    EM_BYTE,
    EM_AMP,
    EM_SEMI,
    EM_HEAD,
    EM_NAME,
    EM_UTF
  } emit_sel_t;

  typedef struct packed {
    logic      take;
    logic      set_ent;
    logic      clr_ent;
    logic      append;
    logic      shift1;
    logic      shift2;
    logic      parse_init;
    logic      parse_step;
    logic      utf_init;
    logic      utf_step;
    logic      emit;
    logic      emit_last;
    emit_sel_t sel;
  } xed_cmd_t;

  typedef struct packed {
    logic in_ent;
    logic byte_amp;
    logic byte_semi;
    logic end_flag;
    logic name_hit;
    logic num_start;
    logic cnt_zero;
    logic cnt_one;
    logic full_next;
    logic head_amp;
    logic next_amp;
    logic digit_ok;
    logic parse_last;
    logic cp_ok;
    logic utf_last;
    logic out_free;
  } xed_stat_t;

endpackage

[sv/xed_ctrl.sv]
// Controller state machine of the entity decoder: sequences accept, resolve, flush and emit.
module xed_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  xed_pkg::xed_stat_t st,
  output xed_pkg::xed_cmd_t  cmd
);

  xed_pkg::state_t state_r;
  xed_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xed_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.sel = xed_pkg::EM_BYTE;
    in_tready = 1'b0;
    case (state_r)
      xed_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          state_nxt = xed_pkg::ST_DECIDE;
        end
      end
      xed_pkg::ST_DECIDE: begin
        if (!st.in_ent) begin
          if (!st.byte_amp) begin
            if (st.out_free) begin
              cmd.emit = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.sel = xed_pkg::EM_BYTE;
              state_nxt = xed_pkg::ST_IDLE;
            end
          end else if (st.end_flag) begin
            if (st.out_free) begin
              cmd.emit = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.sel = xed_pkg::EM_AMP;
              state_nxt = xed_pkg::ST_IDLE;
            end
          end else begin
            cmd.set_ent = 1'b1;
            state_nxt = xed_pkg::ST_IDLE;
          end
        end else if (st.byte_semi) begin
          if (st.name_hit) begin
            if (st.out_free) begin
              cmd.emit = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.sel = xed_pkg::EM_NAME;
              cmd.clr_ent = 1'b1;
              state_nxt = xed_pkg::ST_IDLE;
            end
          end else if (st.num_start) begin
            cmd.parse_init = 1'b1;
            state_nxt = xed_pkg::ST_PARSE;
          end else begin
            state_nxt = xed_pkg::ST_RAW_AMP;
          end
        end else begin
          cmd.append = 1'b1;
          if (st.full_next || st.end_flag) begin
            state_nxt = xed_pkg::ST_FLUSH_AMP;
          end else begin
            state_nxt = xed_pkg::ST_IDLE;
          end
        end
      end
      xed_pkg::ST_FLUSH_AMP: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = xed_pkg::EM_AMP;
          if (st.cnt_zero) begin
            cmd.emit_last = 1'b1;
            cmd.clr_ent = 1'b1;
            state_nxt = xed_pkg::ST_IDLE;
          end else if (!st.end_flag && st.head_amp) begin
            cmd.emit_last = 1'b1;
            cmd.shift1 = 1'b1;
            state_nxt = xed_pkg::ST_IDLE;
          end else begin
            state_nxt = xed_pkg::ST_FLUSH_HELD;
          end
        end
      end
      xed_pkg::ST_FLUSH_HELD: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = xed_pkg::EM_HEAD;
          if (st.cnt_one) begin
            cmd.emit_last = 1'b1;
            cmd.clr_ent = 1'b1;
            state_nxt = xed_pkg::ST_IDLE;
          end else if (!st.end_flag && st.next_amp) begin
            cmd.emit_last = 1'b1;
            cmd.shift2 = 1'b1;
            state_nxt = xed_pkg::ST_IDLE;
          end else begin
            cmd.shift1 = 1'b1;
          end
        end
      end
      xed_pkg::ST_PARSE: begin
        if (!st.digit_ok) begin
          state_nxt = xed_pkg::ST_RAW_AMP;
        end else begin
          cmd.parse_step = 1'b1;
          if (st.parse_last) begin
            state_nxt = xed_pkg::ST_NUM_CHK;
          end
        end
      end
      xed_pkg::ST_NUM_CHK: begin
        if (st.cp_ok) begin
          cmd.utf_init = 1'b1;
          state_nxt = xed_pkg::ST_UTF;
        end else begin
          state_nxt = xed_pkg::ST_RAW_AMP;
        end
      end
      xed_pkg::ST_UTF: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = xed_pkg::EM_UTF;
          cmd.utf_step = 1'b1;
          if (st.utf_last) begin
            cmd.emit_last = 1'b1;
            cmd.clr_ent = 1'b1;
            state_nxt = xed_pkg::ST_IDLE;
          end
        end
      end
      xed_pkg::ST_RAW_AMP: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = xed_pkg::EM_AMP;
          state_nxt = st.cnt_zero ? xed_pkg::ST_RAW_SEMI : xed_pkg::ST_RAW_HELD;
        end
      end
      xed_pkg::ST_RAW_HELD: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel = xed_pkg::EM_HEAD;
          cmd.shift1 = 1'b1;
          if (st.cnt_one) begin
            state_nxt = xed_pkg::ST_RAW_SEMI;
          end
        end
      end
      xed_pkg::ST_RAW_SEMI: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.sel = xed_pkg::EM_SEMI;
          cmd.clr_ent = 1'b1;
          state_nxt = xed_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xed_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/xed_dp.sv]
// Datapath of the entity decoder: held bytes, number parser, UTF-8 encoder and output register.
module xed_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic               out_tuser,
  input  xed_pkg::xed_cmd_t  cmd,
  output xed_pkg::xed_stat_t st
);

  localparam int W = xed_pkg::ENTITY_WINDOW;
  localparam int CW = xed_pkg::CNT_W;
  localparam int IW = xed_pkg::IDX_W;
  localparam int PW = xed_pkg::CP_W;
  localparam int SW = xed_pkg::CP_SUM_W;

  logic [7:0]    held_r [W];
  logic [CW-1:0] cnt_r;
  logic          in_ent_r;
  logic [7:0]    byte_r;
  logic          end_r;
  logic [IW-1:0] idx_r;
  logic          hex_r;
  logic [PW-1:0] cp_r;
  logic [1:0]    uidx_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_user_r;

  logic [7:0]    cur;
  logic          dig_ok;
  logic [3:0]    dig_val;
  logic [SW-1:0] prod;
  logic [SW-1:0] sum;
  logic [PW-1:0] cp_nxt;
  logic [1:0]    ulen;
  logic [7:0]    ubytes [4];
  logic          name_hit;
  logic [7:0]    name_char;
  logic          hex_start;
  logic [7:0]    emit_byte;
  logic          out_free;

  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (hex && c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (hex && c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign out_free = !out_valid_r || out_tready;
  assign cur = held_r[idx_r];
  assign {dig_ok, dig_val} = digit_of(cur, hex_r);

  always_comb begin
    prod = hex_r ? {cp_r, 4'b0} : ({1'b0, cp_r, 3'b0} + {3'b0, cp_r, 1'b0});
    sum = prod + {{(SW - 4){1'b0}}, dig_val};
    cp_nxt = (sum > SW'(xed_pkg::CP_MAX)) ? xed_pkg::CP_SAT : sum[PW-1:0];
  end

  always_comb begin
    name_hit = 1'b1;
    name_char = xed_pkg::CH_AMP;
    if (cnt_r == CW'(3) && {held_r[0], held_r[1], held_r[2]} == "amp") begin
      name_char = xed_pkg::CH_AMP;
    end else if (cnt_r == CW'(2) && {held_r[0], held_r[1]} == "lt") begin
      name_char = xed_pkg::CH_LT;
    end else if (cnt_r == CW'(2) && {held_r[0], held_r[1]} == "gt") begin
      name_char = xed_pkg::CH_GT;
    end else if (cnt_r == CW'(4) && {held_r[0], held_r[1], held_r[2], held_r[3]} == "quot") begin
      name_char = xed_pkg::CH_QUOT;
    end else if (cnt_r == CW'(4) && {held_r[0], held_r[1], held_r[2], held_r[3]} == "apos") begin
      name_char = xed_pkg::CH_APOS;
    end else if (cnt_r == CW'(4) && {held_r[0], held_r[1], held_r[2], held_r[3]} == "nbsp") begin
      name_char = xed_pkg::CH_SPACE;
    end else begin
      name_hit = 1'b0;
    end
  end

  always_comb begin
    ubytes[0] = {1'b0, cp_r[6:0]};
    ubytes[1] = 8'h00;
    ubytes[2] = 8'h00;
    ubytes[3] = 8'h00;
    if (cp_r < PW'(12'h800) && cp_r >= PW'(8'h80)) begin
      ulen = 2'd1;
      ubytes[0] = {3'b110, cp_r[10:6]};
      ubytes[1] = {2'b10, cp_r[5:0]};
    end else if (cp_r < PW'(20'h10000) && cp_r >= PW'(12'h800)) begin
      ulen = 2'd2;
      ubytes[0] = {4'b1110, cp_r[15:12]};
      ubytes[1] = {2'b10, cp_r[11:6]};
      ubytes[2] = {2'b10, cp_r[5:0]};
    end else if (cp_r >= PW'(20'h10000)) begin
      ulen = 2'd3;
      ubytes[0] = {5'b11110, cp_r[20:18]};
      ubytes[1] = {2'b10, cp_r[17:12]};
      ubytes[2] = {2'b10, cp_r[11:6]};
      ubytes[3] = {2'b10, cp_r[5:0]};
    end else begin
      ulen = 2'd0;
    end
  end

  always_comb begin
    case (cmd.sel)
      xed_pkg::EM_BYTE: emit_byte = byte_r;
      xed_pkg::EM_AMP:  emit_byte = xed_pkg::CH_AMP;
      xed_pkg::EM_SEMI: emit_byte = xed_pkg::CH_SEMI;
      xed_pkg::EM_HEAD: emit_byte = held_r[0];
      xed_pkg::EM_NAME: emit_byte = name_char;
      xed_pkg::EM_UTF:  emit_byte = ubytes[uidx_r];
      default:          emit_byte = byte_r;
    endcase
  end

  assign hex_start = cnt_r > CW'(2) &&
                     (held_r[1] == xed_pkg::CH_LX || held_r[1] == xed_pkg::CH_UX);

  always_comb begin
    st.in_ent = in_ent_r;
    st.byte_amp = byte_r == xed_pkg::CH_AMP;
    st.byte_semi = byte_r == xed_pkg::CH_SEMI;
    st.end_flag = end_r;
    st.name_hit = name_hit;
    st.num_start = cnt_r >= CW'(2) && held_r[0] == xed_pkg::CH_HASH;
    st.cnt_zero = cnt_r == '0;
    st.cnt_one = cnt_r == CW'(1);
    st.full_next = cnt_r == CW'(W - 1);
    st.head_amp = held_r[0] == xed_pkg::CH_AMP;
    st.next_amp = held_r[1] == xed_pkg::CH_AMP;
    st.digit_ok = dig_ok;
    st.parse_last = (CW'(idx_r) + CW'(1)) == cnt_r;
    st.cp_ok = cp_r != '0 && cp_r <= xed_pkg::CP_MAX;
    st.utf_last = uidx_r == ulen;
    st.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ent_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cmd.clr_ent) begin
        in_ent_r <= 1'b0;
        cnt_r <= '0;
      end else if (cmd.set_ent) begin
        in_ent_r <= 1'b1;
        cnt_r <= '0;
      end else if (cmd.append) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.shift2) begin
        cnt_r <= cnt_r - CW'(2);
      end else if (cmd.shift1) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      held_r[cnt_r[IW-1:0]] <= byte_r;
    end else if (cmd.shift2) begin
      for (int i = 0; i < W - 2; i++) begin
        held_r[i] <= held_r[i+2];
      end
    end else if (cmd.shift1) begin
      for (int i = 0; i < W - 1; i++) begin
        held_r[i] <= held_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_tdata;
      end_r <= in_tlast;
    end
    if (cmd.parse_init) begin
      hex_r <= hex_start;
      idx_r <= hex_start ? IW'(2) : IW'(1);
      cp_r <= '0;
    end else if (cmd.parse_step) begin
      cp_r <= cp_nxt;
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.utf_init) begin
      uidx_r <= 2'd0;
    end else if (cmd.utf_step) begin
      uidx_r <= uidx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.emit_last;
      out_user_r <= cmd.emit_last & end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_byte_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_user_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(W))
    else $error("held count beyond window");

  a_empty_outside: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ent_r |-> cnt_r == '0)
    else $error("bytes held outside an entity");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result overwritten before transfer");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r |-> out_last_r)
    else $error("text end flag on a non-final result");

endmodule

[sv/xml_entity_decoder.sv]
// Top level of the XML character entity decoder (byte stream in, UTF-8 byte stream out).
//
//  channel | dir | tdata                | tlast               | tuser
//  in_     | in  | [7:0] text_byte      | text_end            | -
//  out_    | out | [7:0] out_byte       | run_last            | text_done
//
// A plain byte is accepted, then loaded into the result register once that is free.
// A named entity resolves on ';' in the decide state; a numeric one parses its digits,
// then passes a range check and emits its UTF-8 bytes. Unknown entities, full windows
// and end-of-text flushes send one byte per cycle while the output register is free.
// Reset leaves the block idle outside any entity; held bytes need no clearing.
// Every result waits for a free output register; the next transaction is
// accepted while the last result is still waiting.
module xml_entity_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] text_done
);

  xed_pkg::xed_cmd_t  cmd;
  xed_pkg::xed_stat_t st;

  xed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  xed_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

[verif/xml_entity_decoder_tb.sv]
// Self-checking testbench for the XML entity decoder: directed and random text against a behavioral decoder.
module xml_entity_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_done;
  } decoded_byte_t;

  typedef enum int {SINK_OPEN, SINK_BUSY, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

  typedef enum int {
    TK_PLAIN, TK_NAMED, TK_DECIMAL, TK_HEX, TK_UNKNOWN, TK_LONG, TK_BADNUM, TK_NOISE
  } token_kind_t;

  localparam int RANDOM_BYTES = 130;
  localparam int MAX_RUN = xed_pkg::ENTITY_WINDOW + 1;
  localparam int MAX_REPORTS = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  logic [7:0]    held_q [xed_pkg::ENTITY_WINDOW];
  int            held_n = 0;
  bit            ent_open = 1'b0;
  logic [7:0]    rescan_q [$];
  logic [7:0]    run_bytes [$];
  decoded_byte_t decoded_q [$];
  logic [7:0]    token_q [$];
  int            err_count = 0;
  int            burst_left = 0;
  sink_mode_t    sink_mode = SINK_OPEN;
  int            sink_left = 0;

  xml_entity_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void put_byte(logic [7:0] b);
    if (run_bytes.size() < MAX_RUN) run_bytes.insert(run_bytes.size(), b);
  endfunction

  function automatic bit name_eq(string s);
    if (held_n != s.len()) return 1'b0;
    for (int k = 0; k < s.len(); k++) begin
      if (held_q[k] != s[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void put_utf8(logic [31:0] cp);
    if (cp < 32'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void resolve_entity();
    bit          ok;
    bit          hex;
    logic [31:0] cp;
    int          d;
    ok = 1'b0;
    cp = '0;
    if (name_eq("amp")) put_byte(xed_pkg::CH_AMP);
    else if (name_eq("lt")) put_byte(xed_pkg::CH_LT);
    else if (name_eq("gt")) put_byte(xed_pkg::CH_GT);
    else if (name_eq("quot")) put_byte(xed_pkg::CH_QUOT);
    else if (name_eq("apos")) put_byte(xed_pkg::CH_APOS);
    else if (name_eq("nbsp")) put_byte(xed_pkg::CH_SPACE);
    else begin
      if (held_n >= 1 && held_q[0] == xed_pkg::CH_HASH) begin
        hex = held_n > 2 && (held_q[1] == xed_pkg::CH_LX || held_q[1] == xed_pkg::CH_UX);
        for (int k = hex ? 2 : 1; k < held_n; k++) begin
          if (hex) d = hex_value(held_q[k]);
          else d = (held_q[k] >= "0" && held_q[k] <= "9") ? int'(held_q[k] - "0") : -1;
          if (d < 0) begin
            ok = 1'b0;
            break;
          end
          cp = cp * (hex ? 16 : 10) + d;
          if (cp > 32'(xed_pkg::CP_MAX)) cp = 32'(xed_pkg::CP_SAT);
          ok = 1'b1;
        end
      end
      if (ok && cp >= 1 && cp <= 32'(xed_pkg::CP_MAX)) begin
        put_utf8(cp);
      end else begin
        put_byte(xed_pkg::CH_AMP);
        for (int k = 0; k < held_n; k++) put_byte(held_q[k]);
        put_byte(xed_pkg::CH_SEMI);
      end
    end
    ent_open = 1'b0;
    held_n = 0;
  endfunction

  // emit '&' and queue the held bytes ahead of anything still waiting for a rescan
  function automatic void flush_entity();
    ent_open = 1'b0;
    put_byte(xed_pkg::CH_AMP);
    for (int k = held_n - 1; k >= 0; k--) rescan_q.push_front(held_q[k]);
    held_n = 0;
  endfunction

  function automatic void scan_bytes();
    logic [7:0] b;
    while (rescan_q.size() != 0) begin
      b = rescan_q.pop_front();
      if (!ent_open) begin
        if (b == xed_pkg::CH_AMP) begin
          ent_open = 1'b1;
          held_n = 0;
        end else begin
          put_byte(b);
        end
      end else if (b == xed_pkg::CH_SEMI) begin
        resolve_entity();
      end else begin
        if (held_n < xed_pkg::ENTITY_WINDOW) begin
          held_q[held_n] = b;
          held_n++;
        end
        if (held_n >= xed_pkg::ENTITY_WINDOW) flush_entity();
      end
    end
  endfunction

  function automatic void decode_text_byte(logic [7:0] b, logic last);
    decoded_byte_t item;
    run_bytes.delete();
    rescan_q.insert(rescan_q.size(), b);
    scan_bytes();
    if (last) begin
      while (ent_open) begin
        flush_entity();
        scan_bytes();
      end
    end
    foreach (run_bytes[k]) begin
      item.ch = run_bytes[k];
      item.run_last = (k == run_bytes.size() - 1);
      item.text_done = item.run_last && last;
      decoded_q.insert(decoded_q.size(), item);
    end
  endfunction

  function automatic void note_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %h last %b done %b",
                                out_tdata, out_tlast, out_tuser));
      end else begin
        if (out_tdata !== decoded_q[0].ch || out_tlast !== decoded_q[0].run_last ||
            out_tuser !== decoded_q[0].text_done)
          note_mismatch($sformatf("expected byte %h last %b done %b, got %h %b %b",
                                  decoded_q[0].ch, decoded_q[0].run_last,
                                  decoded_q[0].text_done, out_tdata, out_tlast, out_tuser));
        decoded_q.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(20, 80);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:     out_tready <= 1'b1;
      SINK_BUSY:     out_tready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: out_tready <= (sink_left % 3 == 0);
      default:       out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_text_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_text_byte(b, last);
  endtask

  task automatic send_text(input string s, input bit end_here);
    for (int k = 0; k < s.len(); k++) send_text_byte(s[k], end_here && k == s.len() - 1);
  endtask

  function automatic void push_text(string s);
    for (int k = 0; k < s.len(); k++) token_q.insert(token_q.size(), s[k]);
  endfunction

  function automatic logic [31:0] pick_code_point(bit hex);
    logic [31:0] bounds [9] = '{32'h1, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                                32'h10000, 32'h10FFFF, 32'h110000};
    case ($urandom_range(0, 6))
      0: return $urandom_range(1, 32'h7F);
      1: return $urandom_range(32'h80, 32'h7FF);
      2: return $urandom_range(32'h800, 32'hFFFF);
      3: return $urandom_range(32'h10000, 32'h10FFFF);
      4: return $urandom_range(32'hD800, 32'hDFFF);
      5: return hex ? $urandom_range(32'h110000, 32'hFFFFFF) : $urandom_range(1114112, 9999999);
      default: return bounds[$urandom_range(0, 8)];
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] b;
    b = 8'($urandom_range(8'h21, 8'h7E));
    if (b == xed_pkg::CH_AMP || b == xed_pkg::CH_SEMI) b = "q";
    return b;
  endfunction

  task automatic build_token();
    token_kind_t kind;
    int          r;
    logic [7:0]  b;
    logic [31:0] cp;
    string       digits;
    string       names [6] = '{"amp", "lt", "gt", "quot", "apos", "nbsp"};
    token_q.delete();
    r = $urandom_range(0, 99);
    kind = r < 30 ? TK_PLAIN : r < 48 ? TK_NAMED : r < 60 ? TK_DECIMAL : r < 74 ? TK_HEX :
           r < 82 ? TK_UNKNOWN : r < 88 ? TK_LONG : r < 94 ? TK_BADNUM : TK_NOISE;
    case (kind)
      TK_PLAIN: begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(0, 255));
          if (b == xed_pkg::CH_AMP) b = xed_pkg::CH_SPACE;
          token_q.insert(token_q.size(), b);
        end
      end
      TK_NAMED: begin
        digits = names[$urandom_range(0, 5)];
        if ($urandom_range(0, 7) == 0) digits = digits.toupper();
        token_q.insert(token_q.size(), xed_pkg::CH_AMP);
        push_text(digits);
        token_q.insert(token_q.size(), xed_pkg::CH_SEMI);
      end
      TK_DECIMAL: begin
        cp = pick_code_point(1'b0);
        push_text("&#");
        repeat ($urandom_range(0, 2)) token_q.insert(token_q.size(), "0");
        push_text($sformatf("%0d", cp));
        token_q.insert(token_q.size(), xed_pkg::CH_SEMI);
      end
      TK_HEX: begin
        cp = pick_code_point(1'b1);
        digits = $sformatf("%0h", cp);
        if ($urandom_range(0, 1)) digits = digits.toupper();
        token_q.insert(token_q.size(), xed_pkg::CH_AMP);
        token_q.insert(token_q.size(), xed_pkg::CH_HASH);
        token_q.insert(token_q.size(), $urandom_range(0, 1) ? xed_pkg::CH_LX : xed_pkg::CH_UX);
        repeat ($urandom_range(0, 2)) token_q.insert(token_q.size(), "0");
        push_text(digits);
        token_q.insert(token_q.size(), xed_pkg::CH_SEMI);
      end
      TK_UNKNOWN: begin
        token_q.insert(token_q.size(), xed_pkg::CH_AMP);
        repeat ($urandom_range(0, 10)) token_q.insert(token_q.size(), name_char());
        token_q.insert(token_q.size(), xed_pkg::CH_SEMI);
      end
      TK_LONG: begin
        token_q.insert(token_q.size(), xed_pkg::CH_AMP);
        repeat ($urandom_range(11, 14)) begin
          b = ($urandom_range(0, 5) == 0) ? xed_pkg::CH_AMP : name_char();
          token_q.insert(token_q.size(), b);
        end
        if ($urandom_range(0, 1)) token_q.insert(token_q.size(), xed_pkg::CH_SEMI);
      end
      TK_BADNUM: begin
        case ($urandom_range(0, 3))
          0: push_text("&#;");
          1: push_text("&#x;");
          2: push_text($sformatf("&#%0dg%0d;", $urandom_range(0, 99), $urandom_range(0, 9)));
          default: push_text($sformatf("&#x%0hz;", $urandom_range(0, 255)));
        endcase
      end
      default: begin
        case ($urandom_range(0, 2))
          0: token_q.insert(token_q.size(), xed_pkg::CH_AMP);
          1: token_q.insert(token_q.size(), xed_pkg::CH_SEMI);
          default: token_q.insert(token_q.size(), xed_pkg::CH_HASH);
        endcase
      end
    endcase
  endtask

  task automatic test_passthrough();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text("<", 1'b1);
  endtask

  task automatic test_bad_entities();
    send_text("&#0;", 1'b0);
    send_text("&#x;", 1'b0);
    send_text("&Lt;", 1'b0);
    send_text("&#9999999;", 1'b0);
    send_text("&;", 1'b0);
  endtask

  task automatic test_window_overflow();
    send_text("&ab&cdefghij;", 1'b0);
  endtask

  task automatic test_text_end();
    send_text("&#x41", 1'b1);
    send_text("&", 1'b1);
    send_text("&amp;", 1'b1);
  endtask

  task automatic test_random_text();
    int sent;
    int cut;
    bit stop;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_token();
      stop = (sent + token_q.size() >= RANDOM_BYTES) || ($urandom_range(0, 9) == 0);
      // cut a token short and end the text inside it
      if (token_q.size() > 1 && $urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, token_q.size() - 1);
        while (token_q.size() > cut) token_q.delete(token_q.size() - 1);
        stop = 1'b1;
      end
      foreach (token_q[k]) send_text_byte(token_q[k], stop && k == token_q.size() - 1);
      sent += token_q.size();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_passthrough();
    test_bad_entities();
    test_window_overflow();
    test_text_end();
    test_random_text();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("PASS xml_entity_decoder");
    end else begin
      $display("FAIL xml_entity_decoder");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL xml_entity_decoder");
    $finish;
  end

endmodule
